FILE: rtl/edcf_pkg.sv
// Shared types, codes and helpers for the escape deframer with credit flow.
// No dependencies; used by the channel interfaces, the step logic and the top level.
`timescale 1ns / 1ps

package edcf_pkg;

  typedef enum logic [1:0] {
    ActLink     = 2'd0,
    ActPayload  = 2'd1,
    ActLogicRst = 2'd2,
    ActCommRst  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StRefused  = 2'd1,
    StNoCredit = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhEsc  = 3'b010,
    PhCred = 3'b100
  } phase_e;

  localparam logic       DestHost     = 1'b0;
  localparam logic       DestLink     = 1'b1;
  localparam logic [7:0] EscByte      = 8'hfe;
  localparam logic [7:0] RstLogicCode = 8'h81;
  localparam logic [7:0] RstCommCode  = 8'h85;
  localparam logic [7:0] CreditLsb    = 8'h01;
  localparam logic [14:0] TrancheRst  = 15'h3fff;
  localparam logic [23:0] AllowMax    = 24'hffffff;
  localparam int unsigned MaxResults  = 4;

  typedef struct packed {
    action_e    action;
    logic [7:0] in_byte;
    logic       reset_level;
  } in_t;

  typedef struct packed {
    logic       dest;
    logic [7:0] out_byte;
    logic       last;
    status_e    status;
  } out_t;

  typedef struct packed {
    phase_e      phase;
    logic [6:0]  credit_high_bits;
    logic [15:0] receive_credit;
    logic [23:0] send_allowance;
  } state_t;

  typedef struct packed {
    logic [2:0]                count;
    out_t [MaxResults-1:0]     item;
  } step_res_t;

  function automatic out_t mk_out(logic dest, logic [7:0] b, logic last, status_e st);
    out_t o;
    o.dest     = dest;
    o.out_byte = b;
    o.last     = last;
    o.status   = st;
    return o;
  endfunction

endpackage

FILE: rtl/edcf_if.sv
// Valid/ready channel interfaces: link/host input items, results, and tranche writes.
// Depends on edcf_pkg for the payload types.
`timescale 1ns / 1ps

interface edcf_in_if;
  logic          valid;
  logic          ready;
  edcf_pkg::in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface edcf_out_if;
  logic           valid;
  logic           ready;
  edcf_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface edcf_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/edcf_step.sv
// Single-pass item logic: next link state and up to four results for one item.
// Depends on edcf_pkg.
`timescale 1ns / 1ps

module edcf_step #(
  parameter int unsigned BUFFER_BYTES = 32768
) (
  input  edcf_pkg::state_t    state_i,
  input  edcf_pkg::in_t       item_i,
  input  logic [14:0]         tranche_i,
  output edcf_pkg::state_t    state_o,
  output edcf_pkg::step_res_t res_o
);

  localparam logic [16:0] BufBytes = 17'(BUFFER_BYTES);

  logic        deliver;
  logic        no_credit;
  logic [15:0] rc_dec;
  logic [15:0] rc_sum;
  logic [16:0] limit;
  logic        grant;
  logic [24:0] allow_sum;
  logic [7:0]  rst_byte;

  assign no_credit = (state_i.receive_credit == 16'd0);
  assign rc_dec    = no_credit ? state_i.receive_credit : state_i.receive_credit - 16'd1;
  assign rc_sum    = rc_dec + {1'b0, tranche_i};
  assign limit     = BufBytes - {2'b00, tranche_i};
  assign grant     = (tranche_i != 15'd0) && ({2'b00, tranche_i} < BufBytes) &&
                     ({1'b0, rc_dec} < limit);
  assign allow_sum = {1'b0, state_i.send_allowance} +
                     {10'd0, state_i.credit_high_bits, item_i.in_byte};
  assign rst_byte  = ((item_i.action == edcf_pkg::ActCommRst) ? edcf_pkg::RstCommCode
                                                               : edcf_pkg::RstLogicCode)
                     | {6'd0, item_i.reset_level, 1'b0};

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    deliver = 1'b0;
    unique case (item_i.action)
      edcf_pkg::ActLink: begin
        unique case (state_i.phase)
          edcf_pkg::PhEsc: begin
            if (item_i.in_byte == edcf_pkg::EscByte) begin
              state_o.phase = edcf_pkg::PhIdle;
              deliver       = 1'b1;
            end else begin
              state_o.credit_high_bits = item_i.in_byte[7:1];
              state_o.phase            = edcf_pkg::PhCred;
            end
          end
          edcf_pkg::PhCred: begin
            state_o.send_allowance = allow_sum[24] ? edcf_pkg::AllowMax : allow_sum[23:0];
            state_o.phase          = edcf_pkg::PhIdle;
          end
          edcf_pkg::PhIdle: begin
            if (item_i.in_byte == edcf_pkg::EscByte) begin
              state_o.phase = edcf_pkg::PhEsc;
            end else begin
              deliver = 1'b1;
            end
          end
          default: begin
            state_o.phase = edcf_pkg::PhIdle;
          end
        endcase
      end
      edcf_pkg::ActPayload: begin
        res_o.count = 3'd1;
        if (state_i.send_allowance != 24'd0) begin
          state_o.send_allowance = state_i.send_allowance - 24'd1;
          res_o.item[0] = edcf_pkg::mk_out(edcf_pkg::DestLink, item_i.in_byte, 1'b1,
                                            edcf_pkg::StOk);
        end else begin
          res_o.item[0] = edcf_pkg::mk_out(edcf_pkg::DestHost, 8'h00, 1'b1,
                                            edcf_pkg::StRefused);
        end
      end
      edcf_pkg::ActLogicRst, edcf_pkg::ActCommRst: begin
        res_o.count   = 3'd2;
        res_o.item[0] = edcf_pkg::mk_out(edcf_pkg::DestLink, edcf_pkg::EscByte, 1'b0,
                                          edcf_pkg::StOk);
        res_o.item[1] = edcf_pkg::mk_out(edcf_pkg::DestLink, rst_byte, 1'b1,
                                          edcf_pkg::StOk);
      end
    endcase

    if (deliver) begin
      res_o.item[0] = edcf_pkg::mk_out(edcf_pkg::DestHost, item_i.in_byte, !grant,
                                        no_credit ? edcf_pkg::StNoCredit : edcf_pkg::StOk);
      if (grant) begin
        state_o.receive_credit = rc_sum;
        res_o.count   = 3'd4;
        res_o.item[1] = edcf_pkg::mk_out(edcf_pkg::DestLink, edcf_pkg::EscByte, 1'b0,
                                          edcf_pkg::StOk);
        res_o.item[2] = edcf_pkg::mk_out(edcf_pkg::DestLink,
                                          edcf_pkg::CreditLsb | {tranche_i[14:8], 1'b0},
                                          1'b0, edcf_pkg::StOk);
        res_o.item[3] = edcf_pkg::mk_out(edcf_pkg::DestLink, tranche_i[7:0], 1'b1,
                                          edcf_pkg::StOk);
      end else begin
        state_o.receive_credit = rc_dec;
        res_o.count = 3'd1;
      end
    end
  end

endmodule

FILE: rtl/escape_deframer_credit_flow.sv
// The first result passes through the input register and then the result buffer.
// Throughput: one item per cycle while the result channel accepts and each item yields at most
// one result; an item with k results holds the four-entry result buffer for k output transfers.
// Items that yield no result (escape and credit bytes) leave the result buffer empty.
// Reset: asynchronous, active low; credit tranche and receive credit 0x3fff, allowance 0.
`timescale 1ns / 1ps

module escape_deframer_credit_flow #(
  parameter int unsigned BUFFER_BYTES = 32768
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  edcf_in_if.sink           in_i,
  edcf_out_if.source        out_o,
  edcf_cfg_if.sink          cfg_i
);

  logic                                       in_vld_q;
  edcf_pkg::in_t                              in_q;
  edcf_pkg::state_t                           state_q, state_d;
  edcf_pkg::step_res_t                        step_res;
  logic [14:0]                                tranche_q;
  edcf_pkg::out_t [edcf_pkg::MaxResults-1:0]  buf_q;
  logic [2:0]                                 cnt_q;
  logic                                       out_xfer;
  logic                                       consume;

  assign out_xfer    = out_o.valid & out_o.ready;
  assign consume     = in_vld_q && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_xfer));
  assign in_i.ready  = !in_vld_q || consume;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid   = (cnt_q != 3'd0);
  assign out_o.payload = buf_q[0];

  edcf_step #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_step (
    .state_i  (state_q),
    .item_i   (in_q),
    .tranche_i(tranche_q),
    .state_o  (state_d),
    .res_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q                <= 1'b0;
      in_q                    <= '0;
      cnt_q                   <= 3'd0;
      tranche_q               <= edcf_pkg::TrancheRst;
      state_q.phase           <= edcf_pkg::PhIdle;
      state_q.credit_high_bits <= 7'd0;
      state_q.receive_credit  <= {1'b0, edcf_pkg::TrancheRst};
      state_q.send_allowance  <= 24'd0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
        in_q     <= in_i.payload;
      end else if (consume) begin
        in_vld_q <= 1'b0;
      end
      if (consume) begin
        cnt_q   <= step_res.count;
        state_q <= state_d;
      end else if (out_xfer) begin
        cnt_q <= cnt_q - 3'd1;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        tranche_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      buf_q <= step_res.item;
    end else if (out_xfer) begin
      buf_q <= {buf_q[edcf_pkg::MaxResults-1], buf_q[edcf_pkg::MaxResults-1:1]};
    end
  end

endmodule

FILE: rtl/edcf_checker.sv
// Port-level checks on the result channel of escape_deframer_credit_flow.
// Depends on edcf_pkg; bound to the top level below.
`timescale 1ns / 1ps

module edcf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input edcf_pkg::out_t out_payload_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_payload_i.last |=> out_valid_i)
    else $error("gap inside a multi-byte result sequence");

  a_refused_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_payload_i.status == edcf_pkg::StRefused) |->
      out_payload_i.last && (out_payload_i.dest == edcf_pkg::DestHost) &&
      (out_payload_i.out_byte == 8'h00))
    else $error("malformed refusal result");

  a_link_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_payload_i.dest == edcf_pkg::DestLink) && !out_payload_i.last |->
      (out_payload_i.out_byte == edcf_pkg::EscByte) || out_payload_i.out_byte[0])
    else $error("unexpected non-final link byte");

endmodule

bind escape_deframer_credit_flow edcf_checker u_edcf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_payload_i(out_o.payload)
);

FILE: sim/testbench.sv
// Self-checking testbench for escape_deframer_credit_flow: deframing, credit grants,
// payload allowance, reset commands and tranche settings checked against a built-in predictor.
// Depends on edcf_pkg, the edcf channel interfaces and the escape_deframer_credit_flow RTL.
`timescale 1ns / 1ps

class credit_link_scoreboard;
  edcf_pkg::out_t   due_results[$];
  edcf_pkg::phase_e deframe_phase;
  logic [6:0]       credit_hi;
  logic [15:0]      rx_credit;
  logic [23:0]      tx_allowance;
  logic [14:0]      tranche;
  int               buffer_bytes;
  int               errors;
  int               items_seen;
  int               results_checked;
  int               grants_seen;
  int               refusals_seen;
  bit               saturated;

  function new(int buf_bytes);
    buffer_bytes    = buf_bytes;
    deframe_phase   = edcf_pkg::PhIdle;
    credit_hi       = '0;
    rx_credit       = {1'b0, edcf_pkg::TrancheRst};
    tx_allowance    = '0;
    tranche         = edcf_pkg::TrancheRst;
    errors          = 0;
    items_seen      = 0;
    results_checked = 0;
    grants_seen     = 0;
    refusals_seen   = 0;
    saturated       = 1'b0;
  endfunction

  function void set_tranche(logic [14:0] value);
    tranche = value;
  endfunction

  function void add_result(logic dest, logic [7:0] value, edcf_pkg::status_e st);
    edcf_pkg::out_t r;
    r.dest     = dest;
    r.out_byte = value;
    r.last     = 1'b0;
    r.status   = st;
    due_results.push_back(r);
  endfunction

  function void deliver_byte(logic [7:0] value);
    edcf_pkg::status_e st;
    st = edcf_pkg::StOk;
    if (rx_credit == 16'd0) begin
      st = edcf_pkg::StNoCredit;
    end else begin
      rx_credit = rx_credit - 16'd1;
    end
    add_result(edcf_pkg::DestHost, value, st);
    if (tranche != 15'd0 && int'(tranche) < buffer_bytes &&
        int'(rx_credit) < buffer_bytes - int'(tranche)) begin
      rx_credit = rx_credit + {1'b0, tranche};
      grants_seen++;
      add_result(edcf_pkg::DestLink, edcf_pkg::EscByte, edcf_pkg::StOk);
      add_result(edcf_pkg::DestLink, {tranche[14:8], 1'b1}, edcf_pkg::StOk);
      add_result(edcf_pkg::DestLink, tranche[7:0], edcf_pkg::StOk);
    end
  endfunction

  function void predict_item(edcf_pkg::in_t it);
    int             first;
    logic [24:0]    sum;
    logic [7:0]     code;
    edcf_pkg::out_t tail;
    first = due_results.size();
    items_seen++;
    case (it.action)
      edcf_pkg::ActLink: begin
        case (deframe_phase)
          edcf_pkg::PhEsc: begin
            if (it.in_byte == edcf_pkg::EscByte) begin
              deframe_phase = edcf_pkg::PhIdle;
              deliver_byte(it.in_byte);
            end else begin
              credit_hi     = it.in_byte[7:1];
              deframe_phase = edcf_pkg::PhCred;
            end
          end
          edcf_pkg::PhCred: begin
            sum = {1'b0, tx_allowance} + {10'b0, credit_hi, it.in_byte};
            if (sum > {1'b0, edcf_pkg::AllowMax}) begin
              sum       = {1'b0, edcf_pkg::AllowMax};
              saturated = 1'b1;
            end
            tx_allowance  = sum[23:0];
            deframe_phase = edcf_pkg::PhIdle;
          end
          default: begin
            if (it.in_byte == edcf_pkg::EscByte) begin
              deframe_phase = edcf_pkg::PhEsc;
            end else begin
              deliver_byte(it.in_byte);
            end
          end
        endcase
      end
      edcf_pkg::ActPayload: begin
        if (tx_allowance != 24'd0) begin
          tx_allowance = tx_allowance - 24'd1;
          add_result(edcf_pkg::DestLink, it.in_byte, edcf_pkg::StOk);
        end else begin
          refusals_seen++;
          add_result(edcf_pkg::DestHost, 8'h00, edcf_pkg::StRefused);
        end
      end
      default: begin
        code = (it.action == edcf_pkg::ActLogicRst) ? edcf_pkg::RstLogicCode
                                                    : edcf_pkg::RstCommCode;
        add_result(edcf_pkg::DestLink, edcf_pkg::EscByte, edcf_pkg::StOk);
        add_result(edcf_pkg::DestLink, code | {6'b0, it.reset_level, 1'b0}, edcf_pkg::StOk);
      end
    endcase
    if (due_results.size() > first) begin
      tail      = due_results.pop_back();
      tail.last = 1'b1;
      due_results.push_back(tail);
    end
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(edcf_pkg::out_t got);
    edcf_pkg::out_t want;
    if (due_results.size() == 0) begin
      $display("%0t: result with nothing expected, dest %0d byte %02h last %0d status %0d",
               $time, got.dest, got.out_byte, got.last, got.status);
      errors++;
      return;
    end
    want = due_results.pop_front();
    results_checked++;
    compare_field("dest", want.dest, got.dest);
    compare_field("out_byte", want.out_byte, got.out_byte);
    compare_field("last", want.last, got.last);
    compare_field("status", int'(want.status), int'(got.status));
  endfunction
endclass

module testbench;

  localparam int BufferBytes = 32768;
  localparam int CycleLimit  = 800000;
  localparam int PhaseItems  = 88;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 250;

  logic clk_i;
  logic rst_ni;

  edcf_in_if  in_if ();
  edcf_out_if out_if ();
  edcf_cfg_if cfg_if ();

  credit_link_scoreboard sb;

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;
  int cycles = 0;
  int items_pushed = 0;
  int tranche_writes = 0;

  escape_deframer_credit_flow #(
    .BUFFER_BYTES(BufferBytes)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.due_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.predict_item(in_if.payload);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.payload);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.set_tranche(cfg_if.data);
      end
    end
  end

  // result sink: random back-pressure, plus one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic push_item(edcf_pkg::action_e act, logic [7:0] value, logic level);
    edcf_pkg::in_t it;
    it.action      = act;
    it.in_byte     = value;
    it.reset_level = level;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    items_pushed++;
  endtask

  task automatic send_link(logic [7:0] value);
    push_item(edcf_pkg::ActLink, value, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_data(logic [7:0] value);
    if (value == edcf_pkg::EscByte) begin
      send_link(edcf_pkg::EscByte);
    end
    send_link(value);
  endtask

  task automatic push_grant_msg(logic [14:0] amount, logic odd);
    logic [7:0] first;
    first = {amount[14:8], odd};
    if (first == edcf_pkg::EscByte) begin
      first[0] = 1'b1;
    end
    send_link(edcf_pkg::EscByte);
    send_link(first);
    send_link(amount[7:0]);
  endtask

  task automatic random_item();
    int         pick;
    logic [7:0] noise;
    logic [14:0] amount;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_data(8'($urandom_range(0, 255)));
    end else if (pick < 46) begin
      send_data(edcf_pkg::EscByte);
    end else if (pick < 60) begin
      amount = ($urandom_range(0, 15) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3));
      push_grant_msg(amount, 1'($urandom_range(0, 3) != 0));
    end else if (pick < 80) begin
      push_item(edcf_pkg::ActPayload, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else if (pick < 86) begin
      push_item(($urandom_range(0, 1) != 0) ? edcf_pkg::ActLogicRst : edcf_pkg::ActCommRst,
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      noise = ($urandom_range(0, 2) == 0) ? edcf_pkg::EscByte : 8'($urandom_range(0, 255));
      send_link(noise);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tranche(logic [14:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tranche_writes++;
  endtask

  initial begin
    logic [14:0] settings[5];
    int          start;
    sb = new(BufferBytes);
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed items under the reset tranche
    push_item(edcf_pkg::ActPayload, 8'hff, 1'b0);
    push_item(edcf_pkg::ActLogicRst, 8'h00, 1'b0);
    push_item(edcf_pkg::ActLogicRst, 8'hff, 1'b1);
    push_item(edcf_pkg::ActCommRst, 8'h00, 1'b0);
    push_item(edcf_pkg::ActCommRst, 8'hff, 1'b1);
    send_link(8'h00);
    send_link(8'hff);
    send_data(edcf_pkg::EscByte);
    push_grant_msg(15'h7fff, 1'b1);
    send_link(edcf_pkg::EscByte);
    send_link(8'h00);
    send_link(8'h02);
    push_item(edcf_pkg::ActPayload, 8'h00, 1'b1);
    push_item(edcf_pkg::ActPayload, 8'hff, 1'b0);
    push_item(edcf_pkg::ActPayload, 8'h5a, 1'b1);
    push_grant_msg(15'h0000, 1'b1);
    wait_drained();

    settings[0] = 15'd1;
    settings[1] = 15'h7fff;
    settings[2] = 15'($urandom_range(1, 32767));
    settings[3] = 15'd256;
    settings[4] = 15'd16384;
    for (int k = 0; k < 5; k++) begin
      write_tranche(settings[k]);
      if (k == 0) begin
        hold_req = 1'b1;
      end
      if (k == 4) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      start = items_pushed;
      while (items_pushed - start < PhaseItems) random_item();
      wait_drained();
    end

    $display("covered %0d items and %0d checked results: %0d credit grants, %0d refused",
             sb.items_seen, sb.results_checked, sb.grants_seen, sb.refusals_seen);
    $display("%0d tranche writes, allowance saturation %s", tranche_writes,
             sb.saturated ? "reached" : "not reached");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: escape_deframer_credit_flow.f
rtl/edcf_pkg.sv
rtl/edcf_if.sv
rtl/edcf_step.sv
rtl/escape_deframer_credit_flow.sv
rtl/edcf_checker.sv
sim/testbench.sv
